// File: hw/rtl/hsb_pkg.sv
// Shared types, constants and helpers for the HSV saturation boost pipeline.
`default_nettype none

package hsb_pkg;

    localparam int PORT_W           = 8;
    localparam int GAIN_W           = 12;
    localparam int GAIN_RESET       = 333;
    localparam int FRAC_W           = 16;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int DIV_STAGES       = 8;
    localparam int DIV_BITS         = 2;
    localparam int PIPE_LATENCY     = 13;

    localparam logic [FRAC_W:0] ONE_Q16 = {1'b1, {FRAC_W{1'b0}}};

    // Hue sectors, named by the colors they span.
    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

    // State carried through the two divider chains.
    typedef struct packed {
        logic [PORT_W-1:0] v;
        logic [PORT_W-1:0] delta;
        logic              clamp;
        logic              gray;
        sector_t           sector;
        logic [PORT_W-1:0] sr;
        logic [FRAC_W-1:0] sl;
        logic [FRAC_W-1:0] sq;
        logic [PORT_W-1:0] fr;
        logic [FRAC_W-1:0] fq;
    } hsb_div_t;

    function automatic logic [PORT_W-1:0] chan_max(
        input logic [PORT_W-1:0] a,
        input logic [PORT_W-1:0] b,
        input logic [PORT_W-1:0] c
    );
        logic [PORT_W-1:0] m;
        begin
            m = a;
            if (b > m)
            begin
                m = b;
            end
            if (c > m)
            begin
                m = c;
            end
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hsb_hue.sv
// Front end: max, delta, hue sector and remainder, then the saturation product.
`default_nettype none

module hsb_hue
    import hsb_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [PORT_W-1:0] red,
    input  wire logic [PORT_W-1:0] green,
    input  wire logic [PORT_W-1:0] blue,
    input  wire logic [GAIN_W-1:0] gain,
    output logic                   out_valid,
    output hsb_div_t               out_data
);

    localparam int CW = (CHANNEL_BITS < PORT_W) ? CHANNEL_BITS : PORT_W;
    localparam logic [PORT_W-1:0] CH_MASK = {PORT_W{1'b1}} >> (PORT_W - CW);
    localparam int PW = PORT_W + GAIN_W;

    logic [PORT_W-1:0] r, g, b, v, mn, delta, a, c, d, hrem;
    sector_t           base, sec;

    logic              vld1_reg;
    logic [PORT_W-1:0] v1_reg, delta1_reg, hrem1_reg;
    sector_t           sec1_reg;

    logic [PW-1:0]     prod;
    hsb_div_t          init;
    logic              vld2_reg;
    hsb_div_t          data2_reg;

    always_comb
    begin
        r = red & CH_MASK;
        g = green & CH_MASK;
        b = blue & CH_MASK;
        v = r;
        if (g > v)
        begin
            v = g;
        end
        if (b > v)
        begin
            v = b;
        end
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
        delta = v - mn;
        // red checked first, then green
        if (r >= v)
        begin
            a = g;
            c = b;
            base = SEC_R_Y;
        end
        else if (g >= v)
        begin
            a = b;
            c = r;
            base = SEC_G_C;
        end
        else
        begin
            a = r;
            c = g;
            base = SEC_B_M;
        end
        if (a >= c)
        begin
            d = a - c;
            if (d == delta)
            begin
                // lands exactly on the next sector boundary
                sec  = sector_t'(base + 3'd1);
                hrem = '0;
            end
            else
            begin
                sec  = base;
                hrem = d;
            end
        end
        else
        begin
            d    = c - a;
            hrem = delta - d;
            sec  = (base == SEC_R_Y) ? SEC_M_R : sector_t'(base - 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        v1_reg     <= v;
        delta1_reg <= delta;
        hrem1_reg  <= hrem;
        sec1_reg   <= sec;
    end

    always_comb
    begin
        prod        = PW'(delta1_reg) * PW'(gain);
        init.v      = v1_reg;
        init.delta  = delta1_reg;
        // s saturates when delta*gain >= 256*v
        init.clamp  = prod >= {{(PW-PORT_W-8){1'b0}}, v1_reg, 8'h00};
        init.gray   = (delta1_reg == '0);
        init.sector = sec1_reg;
        init.sr     = prod[PORT_W+7:8];
        init.sl     = {prod[7:0], {(FRAC_W-8){1'b0}}};
        init.sq     = '0;
        init.fr     = hrem1_reg;
        init.fq     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data2_reg <= init;
    end

    assign out_valid = vld2_reg;
    assign out_data  = data2_reg;

endmodule

`default_nettype wire

// File: hw/rtl/hsb_div_stage.sv
// One registered step of the saturation and hue-fraction dividers.
`default_nettype none

module hsb_div_stage
    import hsb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  hsb_div_t      in_data,
    output logic          out_valid,
    output hsb_div_t      out_data
);

    hsb_div_t        nxt;
    logic [PORT_W:0] ts, tf;
    logic            vld_reg;
    hsb_div_t        data_reg;

    // restoring division, DIV_BITS quotient bits per stage for both chains
    always_comb
    begin
        nxt = in_data;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            ts = {nxt.sr, nxt.sl[FRAC_W-1]};
            nxt.sl = {nxt.sl[FRAC_W-2:0], 1'b0};
            if (ts >= {1'b0, nxt.v})
            begin
                ts     = ts - {1'b0, nxt.v};
                nxt.sq = {nxt.sq[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                nxt.sq = {nxt.sq[FRAC_W-2:0], 1'b0};
            end
            nxt.sr = ts[PORT_W-1:0];

            tf = {nxt.fr, 1'b0};
            if (tf >= {1'b0, nxt.delta})
            begin
                tf     = tf - {1'b0, nxt.delta};
                nxt.fq = {nxt.fq[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                nxt.fq = {nxt.fq[FRAC_W-2:0], 1'b0};
            end
            nxt.fr = tf[PORT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= nxt;
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/hsb_rebuild.sv
// Back end: p, q, t products and sector selection into the output registers.
`default_nettype none

module hsb_rebuild
    import hsb_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  hsb_div_t               in_data,
    output logic                   done,
    output logic [PORT_W-1:0]      red,
    output logic [PORT_W-1:0]      green,
    output logic [PORT_W-1:0]      blue
);

    localparam int CW = (CHANNEL_BITS < PORT_W) ? CHANNEL_BITS : PORT_W;
    localparam logic [PORT_W-1:0] CH_MASK = {PORT_W{1'b1}} >> (PORT_W - CW);
    localparam int SW = FRAC_W + 1;
    localparam int MW = 2 * SW;
    localparam int VW = PORT_W + SW;

    logic [SW-1:0]     s, f_c;
    logic [MW-1:0]     sf, sg;

    logic              vld1_reg, zero1_reg;
    logic [PORT_W-1:0] v1_reg;
    sector_t           sec1_reg;
    logic [SW-1:0]     xp1_reg, xq1_reg, xt1_reg;

    logic [VW-1:0]     pp, pq, pt;
    logic              vld2_reg, zero2_reg;
    logic [PORT_W-1:0] v2_reg, p2_reg, q2_reg, t2_reg;
    sector_t           sec2_reg;

    logic [PORT_W-1:0] r_next, g_next, b_next;
    logic              done_reg;
    logic [PORT_W-1:0] red_reg, green_reg, blue_reg;

    always_comb
    begin
        s   = in_data.clamp ? ONE_Q16 : {1'b0, in_data.sq};
        f_c = ONE_Q16 - {1'b0, in_data.fq};
        sf  = MW'(s) * MW'({1'b0, in_data.fq});
        sg  = MW'(s) * MW'(f_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            done_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        zero1_reg <= in_data.gray || (s == '0);
        v1_reg    <= in_data.v;
        sec1_reg  <= in_data.sector;
        xp1_reg   <= ONE_Q16 - s;
        xq1_reg   <= ONE_Q16 - sf[MW-2:FRAC_W];
        xt1_reg   <= ONE_Q16 - sg[MW-2:FRAC_W];
    end

    always_comb
    begin
        pp = VW'(v1_reg) * VW'(xp1_reg);
        pq = VW'(v1_reg) * VW'(xq1_reg);
        pt = VW'(v1_reg) * VW'(xt1_reg);
    end

    always_ff @(posedge clk)
    begin
        zero2_reg <= zero1_reg;
        v2_reg    <= v1_reg;
        sec2_reg  <= sec1_reg;
        p2_reg    <= pp[FRAC_W+PORT_W-1:FRAC_W];
        q2_reg    <= pq[FRAC_W+PORT_W-1:FRAC_W];
        t2_reg    <= pt[FRAC_W+PORT_W-1:FRAC_W];
    end

    always_comb
    begin
        if (zero2_reg)
        begin
            r_next = v2_reg;
            g_next = v2_reg;
            b_next = v2_reg;
        end
        else
        begin
            case (sec2_reg)
                SEC_R_Y: begin r_next = v2_reg; g_next = t2_reg; b_next = p2_reg; end
                SEC_Y_G: begin r_next = q2_reg; g_next = v2_reg; b_next = p2_reg; end
                SEC_G_C: begin r_next = p2_reg; g_next = v2_reg; b_next = t2_reg; end
                SEC_C_B: begin r_next = p2_reg; g_next = q2_reg; b_next = v2_reg; end
                SEC_B_M: begin r_next = t2_reg; g_next = p2_reg; b_next = v2_reg; end
                default: begin r_next = v2_reg; g_next = p2_reg; b_next = q2_reg; end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= r_next & CH_MASK;
        green_reg <= g_next & CH_MASK;
        blue_reg  <= b_next & CH_MASK;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

// File: hw/rtl/hsv_saturation_boost.sv
// Top level of the per-pixel HSV saturation boost pipeline.
// A result strobes on done once the start transfer has passed the hue, divider and rebuild registers.
// Throughput: one pixel per cycle; busy is always low, since every stage
// advances each cycle and the receiver cannot hold results off.
// The pipe length is set by the 16-bit dividers, two quotient bits per stage.
// Reset: rst_n clears all valid bits and sets the saturation gain to 333.
`default_nettype none

module hsv_saturation_boost
    import hsb_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [PORT_W-1:0] red_in,
    input  wire logic [PORT_W-1:0] green_in,
    input  wire logic [PORT_W-1:0] blue_in,
    input  wire logic              cfg_write,
    input  wire logic [GAIN_W-1:0] cfg_data,
    output logic                   done,
    output logic [PORT_W-1:0]      red_out,
    output logic [PORT_W-1:0]      green_out,
    output logic [PORT_W-1:0]      blue_out
);

    localparam int CW = (CHANNEL_BITS < PORT_W) ? CHANNEL_BITS : PORT_W;
    localparam logic [PORT_W-1:0] CH_MASK = {PORT_W{1'b1}} >> (PORT_W - CW);

    // Saturation gain, 8 fraction bits. Write it only while the pipe is empty; the block does not enforce this.
    logic [GAIN_W-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_W'(GAIN_RESET);
        end
        else if (cfg_write)
        begin
            gain_reg <= cfg_data;
        end
    end

    // No backpressure anywhere in the pipe.
    assign busy = 1'b0;

    logic     accept;
    assign accept = start && !busy;

    // Front end: two stages (hue analysis, saturation product).
    logic     div_vld  [0:DIV_STAGES];
    hsb_div_t div_data [0:DIV_STAGES];

    hsb_hue #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_hue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .red       (red_in),
        .green     (green_in),
        .blue      (blue_in),
        .gain      (gain_reg),
        .out_valid (div_vld[0]),
        .out_data  (div_data[0])
    );

    // Divider chain: saturation = delta*gain*256/v and hue fraction,
    // both 16 quotient bits, two per stage.
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        hsb_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_vld[k]),
            .in_data   (div_data[k]),
            .out_valid (div_vld[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    // Back end: products for p, q, t and the sector mux.
    hsb_rebuild #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_rebuild (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_vld[DIV_STAGES]),
        .in_data  (div_data[DIV_STAGES]),
        .done     (done),
        .red      (red_out),
        .green    (green_out),
        .blue     (blue_out)
    );

    logic [PORT_W-1:0] in_max, out_max;
    assign in_max  = chan_max(red_in & CH_MASK, green_in & CH_MASK, blue_in & CH_MASK);
    assign out_max = chan_max(red_out, green_out, blue_out);

    // Every result traces back to a transfer exactly the pipe depth earlier.
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_LATENCY))
        else $error("result without matching start transfer");

    // Value (max channel) is preserved by the saturation change.
    a_value_kept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_max == $past(in_max, PIPE_LATENCY))
        else $error("max channel changed");

    // Gray pixels come out gray (all three channels equal).
    a_gray_pass: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(red_in == green_in && green_in == blue_in, PIPE_LATENCY)
        |-> red_out == green_out && green_out == blue_out)
        else $error("gray pixel altered");

endmodule

`default_nettype wire

// File: sim/hsv_saturation_boost_tb.sv
// Testbench for hsv_saturation_boost: directed and random pixels against a built-in predictor.
`timescale 1ns / 100ps

module hsv_saturation_boost_tb;
    import hsb_pkg::*;

    typedef struct packed {
        logic [PORT_W-1:0] red;
        logic [PORT_W-1:0] green;
        logic [PORT_W-1:0] blue;
    } pixel_t;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = PIPE_LATENCY + 8;
    localparam int  CH_BITS      = 8;
    localparam logic [PORT_W-1:0] CH_MASK = PORT_W'((1 << CH_BITS) - 1);

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [PORT_W-1:0]  red_in;
    logic [PORT_W-1:0]  green_in;
    logic [PORT_W-1:0]  blue_in;
    logic               cfg_write;
    logic [GAIN_W-1:0]  cfg_data;
    logic               done;
    logic [PORT_W-1:0]  red_out;
    logic [PORT_W-1:0]  green_out;
    logic [PORT_W-1:0]  blue_out;

    // Predictor copy of the gain register.
    logic [GAIN_W-1:0]  gain_shadow;
    // Expected boosted pixels, oldest first.
    pixel_t             boosted_q[$];
    int                 error_count;
    int                 cycle_count;
    int                 idle_pct;

    hsv_saturation_boost #(.CHANNEL_BITS(CH_BITS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // v*frac/65536 with frac a Q16 fraction up to 1.0
    function automatic logic [31:0] scale_by(input logic [31:0] v, input logic [31:0] frac);
        logic [63:0] prod;
        begin
            prod = 64'(v) * 64'(frac);
            return 32'(prod >> 16);
        end
    endfunction

    function automatic pixel_t boost_pixel(input pixel_t px, input logic [GAIN_W-1:0] gain);
        logic [31:0] r, g, b, v, mn, delta, hpos, f, p, q, t;
        logic [63:0] sat;
        sector_t     sector;
        pixel_t      res;
        begin
            r = 32'(px.red & CH_MASK);
            g = 32'(px.green & CH_MASK);
            b = 32'(px.blue & CH_MASK);
            v = r;
            mn = r;
            if (g > v) v = g;
            if (b > v) v = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            delta = v - mn;
            sat = 0;
            if (delta != 0)
            begin
                sat = (64'(delta) * 64'(gain) * 64'd256) / 64'(v);
                if (sat > 64'd65536) sat = 64'd65536;
            end
            if (sat == 0)
            begin
                res.red = v[7:0];
                res.green = v[7:0];
                res.blue = v[7:0];
            end
            else
            begin
                if (r >= v)
                    hpos = (g >= b) ? g - b : 6 * delta - (b - g);
                else if (g >= v)
                    hpos = 2 * delta + b - r;
                else
                    hpos = 4 * delta + r - g;
                sector = sector_t'(hpos / delta);
                f = 32'((64'(hpos % delta) << 16) / 64'(delta));
                p = scale_by(v, 32'd65536 - 32'(sat));
                q = scale_by(v, 32'd65536 - 32'((sat * 64'(f)) >> 16));
                t = scale_by(v, 32'd65536 - 32'((sat * 64'(32'd65536 - f)) >> 16));
                case (sector)
                    SEC_R_Y: res = {v[7:0], t[7:0], p[7:0]};
                    SEC_Y_G: res = {q[7:0], v[7:0], p[7:0]};
                    SEC_G_C: res = {p[7:0], v[7:0], t[7:0]};
                    SEC_C_B: res = {p[7:0], q[7:0], v[7:0]};
                    SEC_B_M: res = {t[7:0], p[7:0], v[7:0]};
                    default: res = {v[7:0], p[7:0], q[7:0]};
                endcase
            end
            return res;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                     cycle_count);
            error_count++;
        end
    endtask

    // Sender: optional random idle cycles, then one start transfer.
    // start stays high after the transfer; wait_idle, or an idle cycle in the next call, drops it.
    task automatic send_pixel(input pixel_t px);
        begin
            while (idle_pct > 0 && $urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start    <= 1'b1;
            red_in   <= px.red;
            green_in <= px.green;
            blue_in  <= px.blue;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            boosted_q.push_back(boost_pixel(px, gain_shadow));
        end
    endtask

    task automatic wait_idle();
        begin
            start <= 1'b0;
            while (boosted_q.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // Gain writes only happen with the pipeline drained.
    task automatic set_gain(input logic [GAIN_W-1:0] gain);
        begin
            wait_idle();
            cfg_write <= 1'b1;
            cfg_data  <= gain;
            @(posedge clk);
            cfg_write <= 1'b0;
            gain_shadow = gain;
        end
    endtask

    task automatic send_rgb(input int r, input int g, input int b);
        begin
            send_pixel({8'(r), 8'(g), 8'(b)});
        end
    endtask

    task automatic test_directed();
        begin
            send_rgb(0, 0, 0);           // black
            send_rgb(255, 255, 255);     // white
            send_rgb(128, 128, 128);     // mid gray
            send_rgb(255, 0, 0);
            send_rgb(255, 255, 0);       // red max, green-blue equals delta
            send_rgb(200, 200, 50);
            send_rgb(0, 255, 0);
            send_rgb(0, 255, 255);
            send_rgb(0, 0, 255);
            send_rgb(255, 0, 255);
            send_rgb(200, 40, 90);       // red max, blue above green
            send_rgb(60, 200, 100);
            send_rgb(100, 30, 220);
            send_rgb(255, 254, 254);     // tiny saturation
            send_rgb(1, 0, 0);
            send_rgb(170, 85, 51);
        end
    endtask

    task automatic test_random(input int count);
        pixel_t px;
        int     kind;
        begin
            for (int i = 0; i < count; i++)
            begin
                kind = $urandom_range(9);
                px = pixel_t'($urandom);
                if (kind == 0)
                begin
                    px.green = px.red;
                    px.blue  = px.red;           // gray
                end
                else if (kind == 1)
                begin
                    px.green = px.red - PORT_W'($urandom_range(3));
                    px.blue  = px.red + PORT_W'($urandom_range(3));
                end
                send_pixel(px);
            end
        end
    endtask

    task automatic test_gain_sweep();
        begin
            set_gain(GAIN_W'(0));
            test_directed();
            test_random(40);
            set_gain('1);
            test_directed();
            test_random(40);
            set_gain(GAIN_W'(1));
            test_random(40);
            set_gain(GAIN_W'(256));
            test_random(40);
        end
    endtask

    // Output monitor: one result per done strobe, no backpressure possible.
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && done)
        begin
            if (boosted_q.size() == 0)
            begin
                report_mismatch("unexpected transfer", 1, 0);
            end
            else
            begin
                want = boosted_q.pop_front();
                if (red_out !== want.red) report_mismatch("red", red_out, want.red);
                if (green_out !== want.green) report_mismatch("green", green_out, want.green);
                if (blue_out !== want.blue) report_mismatch("blue", blue_out, want.blue);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("hsv_saturation_boost_tb: errors");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        error_count = 0;
        idle_pct    = 0;
        gain_shadow = GAIN_W'(GAIN_RESET);
        rst_n     = 1'b0;
        start     = 1'b0;
        red_in    = '0;
        green_in  = '0;
        blue_in   = '0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();                 // reset gain
        idle_pct = 19;
        test_random(300);
        wait_idle();                     // sender holds until pipeline empties
        idle_pct = 73;
        test_random(200);
        idle_pct = 0;
        test_gain_sweep();
        set_gain(GAIN_W'($urandom_range(4095)));
        test_random(300);
        set_gain(GAIN_W'(GAIN_RESET));
        test_random(50);

        wait_idle();
        if (error_count == 0)
            $display("hsv_saturation_boost_tb: clean");
        else
            $display("hsv_saturation_boost_tb: errors");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/hsb_pkg.sv
hw/rtl/hsb_hue.sv
hw/rtl/hsb_div_stage.sv
hw/rtl/hsb_rebuild.sv
hw/rtl/hsv_saturation_boost.sv
sim/hsv_saturation_boost_tb.sv
